// ----- rtl/lag_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_pkg: shared constants and types for the associated Laguerre evaluator
// Fixed-point widths, register codes and the request/response bundles that
// pass between the sequencer and the shared recurrence step unit.
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int FRAC_BITS = 20;
    localparam int X_W       = 24;
    localparam int OUT_W     = 48;
    localparam int DEG_W     = 5;
    localparam int ORD_W     = 4;
    localparam int IDX_W     = DEG_W;

    // Recurrence coefficients (2i - 1 + m) and (i - 1 + m) stay below 2^7
    localparam int COEF_W    = 7;
    localparam int OPA_W     = COEF_W + FRAC_BITS + 1;
    // The 48-bit terms are multiplied in two 24-bit halves
    localparam int HALF_W    = OUT_W / 2;
    localparam int PROD_W    = OPA_W + HALF_W + 1;
    localparam int ACC_W     = OPA_W + OUT_W + 1;
    // Magnitude of the numerator after dropping the fraction bits
    localparam int DVD_W     = 56;
    localparam int DIV_DIGIT = 8;
    localparam int DIV_STEPS = DVD_W / DIV_DIGIT;
    localparam int REM_W     = IDX_W;

    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_SEL   = 2;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_ORDER  = 1'b1;

    localparam logic [DEG_W-1:0] DEGREE_RST = '0;
    localparam logic [ORD_W-1:0] ORDER_RST  = ORD_W'(1);

    localparam logic signed [OUT_W-1:0] ONE =
        {{(OUT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [ORD_W-1:0]        ord;
        logic signed [X_W-1:0]   x;
        logic signed [OUT_W-1:0] l1;
        logic signed [OUT_W-1:0] l0;
    } t_step_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] l2;
        logic                    sat;
    } t_step_out;

endpackage

// ----- rtl/assoc_laguerre_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_laguerre_eval: associated Laguerre polynomial L_n^m(x) in Q27.20
// Three-term recurrence on a shared multiply/divide step unit.
// ----------------------------------------------------------------------------
// Usage:
//   Program degree n (address 0) and order m (address 4) over the APB port
//   while busy is low. Drive i_x_value (Q3.20) and pulse start; the request
//   is taken at an edge where start is high and busy is low.
//   busy stays high until the result has been shown. The result appears on
//   o_poly_value / o_saturated for exactly one cycle with o_done high; the
//   receiver must take it then, there is no back-pressure.
// Sequencing:
//   n = 0 or 1: o_done comes in the cycle after the request.
//   n >= 2: each recurrence step runs 4 partial products plus drain on the
//   one 28x25 multiplier, magnitude, divide cycles at 8 quotient bits each,
//   clamp and handoff, repeated until degree n is reached; o_done follows the
//   last step, and a new request is taken only once busy is low again.
// Reset: degree clears to 0, order to 1, and any item in flight is dropped.
// ----------------------------------------------------------------------------
module assoc_laguerre_eval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lag_pkg::PADDR_W-1:0]        paddr,
    input  logic [lag_pkg::PDATA_W-1:0]        pwdata,
    output logic [lag_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [lag_pkg::X_W-1:0]     i_x_value,
    output logic                               o_done,
    output logic signed [lag_pkg::OUT_W-1:0]   o_poly_value,
    output logic                               o_saturated
);

    typedef enum logic [3:0] {
        TS_IDLE  = 4'b0001,
        TS_ISSUE = 4'b0010,
        TS_WAIT  = 4'b0100,
        TS_DONE  = 4'b1000
    } t_top_state;

    t_top_state                       r_state;
    logic [lag_pkg::DEG_W-1:0]        r_degree;
    logic [lag_pkg::ORD_W-1:0]        r_order;
    logic signed [lag_pkg::X_W-1:0]   r_x;
    logic [lag_pkg::DEG_W-1:0]        r_n;
    logic [lag_pkg::ORD_W-1:0]        r_m;
    logic [lag_pkg::IDX_W-1:0]        r_i;
    logic signed [lag_pkg::OUT_W-1:0] r_l0;
    logic signed [lag_pkg::OUT_W-1:0] r_l1;
    logic                             r_sat;

    logic                             w_accept;
    logic                             w_cfg_wr;
    logic [lag_pkg::ORD_W:0]          w_m1;
    logic signed [lag_pkg::OUT_W-1:0] w_l1_init;
    lag_pkg::t_step_in                w_req;
    lag_pkg::t_step_out               w_rsp;
    logic                             w_step_done;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= lag_pkg::DEGREE_RST;
            r_order  <= lag_pkg::ORDER_RST;
        end else if (w_cfg_wr) begin
            case (paddr[lag_pkg::REG_SEL])
                lag_pkg::REG_DEGREE: r_degree <= pwdata[lag_pkg::DEG_W-1:0];
                lag_pkg::REG_ORDER:  r_order  <= pwdata[lag_pkg::ORD_W-1:0];
                default:             r_degree <= r_degree;
            endcase
        end
    end

    always_comb begin
        case (paddr[lag_pkg::REG_SEL])
            lag_pkg::REG_DEGREE: prdata = lag_pkg::PDATA_W'(r_degree);
            lag_pkg::REG_ORDER:  prdata = lag_pkg::PDATA_W'(r_order);
            default:             prdata = '0;
        endcase
    end

    // L1 = (1 + m) - x
    assign w_m1      = {1'b0, r_order} + lag_pkg::ORD_W'(1);
    assign w_l1_init = lag_pkg::OUT_W'({w_m1, {lag_pkg::FRAC_BITS{1'b0}}})
                     - lag_pkg::OUT_W'(i_x_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            case (r_state)
                TS_IDLE: begin
                    if (w_accept) begin
                        r_state <= (r_degree < lag_pkg::DEG_W'(2)) ? TS_DONE : TS_ISSUE;
                    end
                end
                TS_ISSUE: begin
                    r_state <= TS_WAIT;
                end
                TS_WAIT: begin
                    if (w_step_done) begin
                        r_state <= (r_i == r_n) ? TS_DONE : TS_ISSUE;
                    end
                end
                TS_DONE: begin
                    r_state <= TS_IDLE;
                end
                default: begin
                    r_state <= TS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == TS_IDLE && w_accept) begin
            r_x   <= i_x_value;
            r_n   <= r_degree;
            r_m   <= r_order;
            r_i   <= lag_pkg::IDX_W'(2);
            r_l0  <= lag_pkg::ONE;
            r_l1  <= (r_degree == '0) ? lag_pkg::ONE : w_l1_init;
            r_sat <= 1'b0;
        end else if (r_state == TS_WAIT && w_step_done) begin
            // Advance the recurrence window
            r_l0  <= r_l1;
            r_l1  <= w_rsp.l2;
            r_sat <= r_sat | w_rsp.sat;
            r_i   <= r_i + lag_pkg::IDX_W'(1);
        end
    end

    assign w_req.idx = r_i;
    assign w_req.ord = r_m;
    assign w_req.x   = r_x;
    assign w_req.l1  = r_l1;
    assign w_req.l0  = r_l0;

    lag_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == TS_ISSUE),
        .i_req   (w_req),
        .o_done  (w_step_done),
        .o_rsp   (w_rsp)
    );

    assign busy         = (r_state != TS_IDLE);
    assign o_done       = (r_state == TS_DONE);
    assign o_poly_value = r_l1;
    assign o_saturated  = r_sat;

endmodule

// ----- rtl/lag_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_step: one recurrence step on a shared multiplier and divider
// Forms (a*L1 - c*L0) from four 28x25 partial products, then divides the
// magnitude by i*2^20 eight quotient bits a cycle and clamps to 48 bits.
// ----------------------------------------------------------------------------
module lag_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lag_pkg::t_step_in   i_req,
    output logic                o_done,
    output lag_pkg::t_step_out  o_rsp
);

    typedef enum logic [4:0] {
        SS_IDLE = 5'b00001,
        SS_MUL  = 5'b00010,
        SS_MAG  = 5'b00100,
        SS_DIV  = 5'b01000,
        SS_SAT  = 5'b10000
    } t_step_state;

    t_step_state r_state;
    logic [2:0]  r_phase;
    logic [2:0]  r_cnt;
    logic        r_done;

    logic signed [lag_pkg::OPA_W-1:0]  r_opa_a;
    logic signed [lag_pkg::OPA_W-1:0]  r_opa_c;
    logic signed [lag_pkg::OUT_W-1:0]  r_l1;
    logic signed [lag_pkg::OUT_W-1:0]  r_l0;
    logic [lag_pkg::IDX_W-1:0]         r_idx;
    logic signed [lag_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_hi;
    logic                              r_prod_sub;
    logic signed [lag_pkg::ACC_W-1:0]  r_acc;
    logic                              r_neg;
    logic [lag_pkg::DVD_W-1:0]         r_dvd;
    logic [lag_pkg::REM_W-1:0]         r_rem;
    logic signed [lag_pkg::OUT_W-1:0]  r_l2;
    logic                              r_sat;

    logic [lag_pkg::COEF_W-1:0]        w_coef_a;
    logic [lag_pkg::COEF_W-1:0]        w_coef_c;
    logic signed [lag_pkg::OPA_W-1:0]  w_a;
    logic signed [lag_pkg::OPA_W-1:0]  w_c;
    logic signed [lag_pkg::OPA_W-1:0]  w_mul_a;
    logic signed [lag_pkg::OUT_W-1:0]  w_lsel;
    logic signed [lag_pkg::HALF_W:0]   w_mul_b;
    logic signed [lag_pkg::PROD_W-1:0] w_prod;
    logic signed [lag_pkg::ACC_W-1:0]  w_term;
    logic signed [lag_pkg::ACC_W-1:0]  n_acc;
    logic [lag_pkg::ACC_W-1:0]         w_mag;
    logic [lag_pkg::DVD_W-1:0]         n_dvd;
    logic [lag_pkg::REM_W-1:0]         n_rem;
    logic [lag_pkg::REM_W:0]           w_trial;
    logic                              w_over;
    logic signed [lag_pkg::OUT_W-1:0]  n_l2;

    // Coefficients of the step: a = (2i - 1 + m) - x, c = (i - 1 + m)
    assign w_coef_a = {1'b0, i_req.idx, 1'b0} - lag_pkg::COEF_W'(1)
                    + lag_pkg::COEF_W'(i_req.ord);
    assign w_coef_c = lag_pkg::COEF_W'(i_req.idx) - lag_pkg::COEF_W'(1)
                    + lag_pkg::COEF_W'(i_req.ord);
    assign w_a = {1'b0, w_coef_a, {lag_pkg::FRAC_BITS{1'b0}}}
               - lag_pkg::OPA_W'(i_req.x);
    assign w_c = {1'b0, w_coef_c, {lag_pkg::FRAC_BITS{1'b0}}};

    // Phase 0: a*L1 low, 1: a*L1 high, 2: c*L0 low, 3: c*L0 high
    assign w_mul_a = r_phase[1] ? r_opa_c : r_opa_a;
    assign w_lsel  = r_phase[1] ? r_l0 : r_l1;
    assign w_mul_b = r_phase[0]
                   ? {w_lsel[lag_pkg::OUT_W-1], w_lsel[lag_pkg::OUT_W-1:lag_pkg::HALF_W]}
                   : {1'b0, w_lsel[lag_pkg::HALF_W-1:0]};
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_term = r_prod_hi ? (lag_pkg::ACC_W'(r_prod) <<< lag_pkg::HALF_W)
                              : lag_pkg::ACC_W'(r_prod);
    assign n_acc  = r_prod_sub ? (r_acc - w_term) : (r_acc + w_term);

    assign w_mag = r_acc[lag_pkg::ACC_W-1] ? (lag_pkg::ACC_W'(0) - r_acc) : r_acc;

    // Eight restoring divide steps; quotient bits fill the vacated low end
    always_comb begin
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < lag_pkg::DIV_DIGIT; k++) begin
            w_trial = {n_rem, n_dvd[lag_pkg::DVD_W-1]};
            if (w_trial >= {1'b0, r_idx}) begin
                n_rem = lag_pkg::REM_W'(w_trial - {1'b0, r_idx});
                n_dvd = {n_dvd[lag_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[lag_pkg::REM_W-1:0];
                n_dvd = {n_dvd[lag_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    // Clamp: positive limit 2^47-1, negative limit 2^47 in magnitude
    always_comb begin
        if (r_neg) begin
            w_over = (|r_dvd[lag_pkg::DVD_W-1:lag_pkg::OUT_W])
                   || (r_dvd[lag_pkg::OUT_W-1] && (|r_dvd[lag_pkg::OUT_W-2:0]));
        end else begin
            w_over = |r_dvd[lag_pkg::DVD_W-1:lag_pkg::OUT_W-1];
        end
        if (w_over) begin
            n_l2 = r_neg ? lag_pkg::OUT_MIN : lag_pkg::OUT_MAX;
        end else if (r_neg) begin
            n_l2 = lag_pkg::OUT_W'(0) - r_dvd[lag_pkg::OUT_W-1:0];
        end else begin
            n_l2 = r_dvd[lag_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_phase <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SS_IDLE: begin
                    if (i_start) begin
                        r_phase <= '0;
                        r_state <= SS_MUL;
                    end
                end
                SS_MUL: begin
                    r_phase <= r_phase + 3'd1;
                    if (r_phase[2]) begin
                        r_state <= SS_MAG;
                    end
                end
                SS_MAG: begin
                    r_cnt   <= '0;
                    r_state <= SS_DIV;
                end
                SS_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'(lag_pkg::DIV_STEPS - 1)) begin
                        r_state <= SS_SAT;
                    end
                end
                SS_SAT: begin
                    r_done  <= 1'b1;
                    r_state <= SS_IDLE;
                end
                default: begin
                    r_state <= SS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    r_opa_a <= w_a;
                    r_opa_c <= w_c;
                    r_l1    <= i_req.l1;
                    r_l0    <= i_req.l0;
                    r_idx   <= i_req.idx;
                    r_acc   <= '0;
                end
            end
            SS_MUL: begin
                if (!r_phase[2]) begin
                    r_prod     <= w_prod;
                    r_prod_hi  <= r_phase[0];
                    r_prod_sub <= r_phase[1];
                end
                // Accumulate the product registered in the previous phase
                if (r_phase != 3'd0) begin
                    r_acc <= n_acc;
                end
            end
            SS_MAG: begin
                r_neg <= r_acc[lag_pkg::ACC_W-1];
                r_dvd <= w_mag[lag_pkg::FRAC_BITS +: lag_pkg::DVD_W];
                r_rem <= '0;
            end
            SS_DIV: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
            end
            SS_SAT: begin
                r_l2  <= n_l2;
                r_sat <= w_over;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done    = r_done;
    assign o_rsp.l2  = r_l2;
    assign o_rsp.sat = r_sat;

endmodule

// ----- rtl/lag_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_checker: port-level checks for the Laguerre evaluator
// Watches the request/result handshake over time and binds to the top level.
// ----------------------------------------------------------------------------
module lag_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // An accepted request holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // A result is only shown for a request in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe without a request in flight");

    // The block frees up right after showing the result
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

    // busy only drops after a result or a reset
    a_no_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> ($past(o_done) || !$past(i_rst_n)))
        else $error("request dropped without a result");

endmodule

bind assoc_laguerre_eval lag_checker u_lag_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
